// ===== src/sqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_pkg: shared types and codes for the shifting queue with search
//
// Request and response payloads, command and status codes, and the control
// group that the queue controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package sqs_pkg;

    // Command codes carried in the request.
    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_LOC = 2'd2;
    localparam logic [1:0] CMD_REM = 2'd3;

    // Status codes carried in the response.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // One request transfer.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
        logic [4:0]         position;
    } req_t;

    // One response transfer.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [4:0]         found_position;
        logic [4:0]         count;
    } rsp_t;

    // Per-cycle operation broadcast to the cell chain.
    typedef struct packed {
        logic load;    // selected cell takes the enqueue value
        logic shift;   // every cell takes its right neighbor
        logic rotate;  // shift, with the selected cell taking the head
    } cell_ctl_t;

endpackage

// ===== src/sqs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_cell: one storage cell of the queue chain
//
// Holds one 32-bit entry. Each cycle it keeps its value, loads the enqueue
// value, takes its right neighbor's value, or, as the ring tail during a
// rotation, takes the value of the head cell.
// ----------------------------------------------------------------------------
module sqs_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic              clk,
    input  sqs_pkg::cell_ctl_t ctl,
    input  logic [IW-1:0]     sel,
    input  logic [31:0]       load_value,
    input  logic [31:0]       right,
    input  logic [31:0]       head,
    output logic [31:0]       q
);
    import sqs_pkg::*;

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        selected;

    assign selected = (sel == IW'(IDX));

    // Pick the next entry value from the broadcast operation.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.load && selected)
        begin
            data_next = load_value;
        end
        else if (ctl.shift)
        begin
            data_next = right;
        end
        else if (ctl.rotate)
        begin
            data_next = selected ? head : right;
        end
    end

    // Entry storage; contents are meaningless until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ===== src/shifting_queue_with_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_queue_with_search: bounded queue with locate and remove-at
//
// Channel   Handshake              Payload   Direction
// req       req_valid / req_stall  req_t     in   (command, value, position)
// rsp       rsp_valid / rsp_stall  rsp_t     out  (status, data, found, count)
//
// Enqueue, dequeue and every error case load the response register as the
// request transfers: a new request can transfer in every cycle while the
// response register drains. Locate and remove-at on a non-empty queue use
// the transfer, then one ring rotation step for each entry, so the ring is
// rotated once in all, comparing the head cell at each step or extracting
// it at the target step. Reset empties the queue at once; no clearing pass
// is needed. A stalled response holds the final rotation step and blocks
// new requests other than a locate or a valid remove-at on a non-empty queue.
// ----------------------------------------------------------------------------
module shifting_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sqs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sqs_pkg::rsp_t rsp
);
    import sqs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] last_reg, last_next;
    logic [IW-1:0] tgt_reg, tgt_next;
    logic          hit_reg, hit_next;
    logic [4:0]    found_reg, found_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   data_reg, data_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    cell_ctl_t     ctl;
    logic [IW-1:0] sel;
    logic [31:0]   cell_q  [DEPTH];
    logic [31:0]   right_w [DEPTH];
    logic [31:0]   head;

    logic          out_free;
    logic          pos_ok;
    logic          multi;
    logic          accept;
    logic          step_go;
    logic          match;
    logic          rsp_load;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_dec;
    logic [IW:0]   k_ext;
    logic [4:0]    k_pos;
    logic [1:0]    st_v;
    logic [31:0]   data_v;
    logic [4:0]    found_v;

    // Cell chain: each cell hands its entry toward the head.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w[i] = cell_q[i];
        end
        else
        begin : g_mid
            assign right_w[i] = cell_q[i + 1];
        end

        sqs_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .sel        (sel),
            .load_value (req.value),
            .right      (right_w[i]),
            .head       (head),
            .q          (cell_q[i])
        );
    end

    assign head = cell_q[0];

    // Handshake and request classification.
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign pos_ok   = (PW'(req.position) != '0) && (PW'(req.position) <= PW'(cnt_reg));
    assign multi    = (cnt_reg != '0)
                      && ((req.cmd == CMD_LOC) || ((req.cmd == CMD_REM) && pos_ok));
    assign req_stall = (state_reg != S_IDLE) || (!out_free && !multi);
    assign accept    = req_valid && !req_stall;

    assign cnt_inc = cnt_reg + CW'(1);
    assign cnt_dec = cnt_reg - CW'(1);
    assign k_ext   = {1'b0, k_reg} + (IW + 1)'(1);
    assign k_pos   = 5'(k_ext);
    assign step_go = (k_reg != last_reg) || out_free;
    assign match   = (head == val_reg) && !hit_reg;

    // Controller: command decode and ring rotation sequencing.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        tgt_next   = tgt_reg;
        hit_next   = hit_reg;
        found_next = found_reg;
        val_next   = val_reg;
        data_next  = data_reg;
        ctl        = '0;
        sel        = '0;
        rsp_load   = 1'b0;
        st_v       = ST_OK;
        data_v     = '0;
        found_v    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        CMD_ENQ:
                        begin
                            rsp_load = 1'b1;
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                st_v = ST_FULL;
                            end
                            else
                            begin
                                ctl.load = 1'b1;
                                sel      = cnt_reg[IW-1:0];
                                cnt_next = cnt_inc;
                            end
                        end
                        CMD_DEQ:
                        begin
                            rsp_load = 1'b1;
                            if (cnt_reg == '0)
                            begin
                                st_v = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.shift = 1'b1;
                                data_v    = head;
                                cnt_next  = cnt_dec;
                            end
                        end
                        CMD_LOC:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_load = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                k_next     = '0;
                                last_next  = cnt_dec[IW-1:0];
                                hit_next   = 1'b0;
                                found_next = '0;
                                val_next   = req.value;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_load = 1'b1;
                                st_v     = ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                rsp_load = 1'b1;
                                st_v     = ST_BADPOS;
                            end
                            else
                            begin
                                state_next = S_DEL;
                                k_next     = '0;
                                last_next  = cnt_dec[IW-1:0];
                                tgt_next   = IW'(req.position - 5'd1);
                            end
                        end
                    endcase
                end
            end

            // Rotate the ring once, comparing the head at each step.
            S_SCAN:
            begin
                if (step_go)
                begin
                    ctl.rotate = 1'b1;
                    sel        = cnt_dec[IW-1:0];
                    if (match)
                    begin
                        hit_next   = 1'b1;
                        found_next = k_pos;
                    end
                    if (k_reg == last_reg)
                    begin
                        rsp_load   = 1'b1;
                        found_v    = match ? k_pos : found_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + IW'(1);
                    end
                end
            end

            // Rotate the ring once, dropping the target entry on the way.
            S_DEL:
            begin
                if (step_go)
                begin
                    if (k_reg == tgt_reg)
                    begin
                        ctl.shift = 1'b1;
                        data_next = head;
                        cnt_next  = cnt_dec;
                    end
                    else
                    begin
                        ctl.rotate = 1'b1;
                        sel        = cnt_dec[IW-1:0];
                    end
                    if (k_reg == last_reg)
                    begin
                        rsp_load   = 1'b1;
                        data_v     = (k_reg == tgt_reg) ? head : data_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + IW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response register: cleared on transfer, loaded when a command ends.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (rsp_load)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.status         = st_v;
            rsp_next.data_out       = data_v;
            rsp_next.found_position = found_v;
            rsp_next.count          = 5'(cnt_next);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        tgt_reg   <= tgt_next;
        found_reg <= found_next;
        val_reg   <= val_next;
        data_reg  <= data_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The fill level never passes the depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // A rotation is only ever running over a non-empty ring.
    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg != '0) && (k_reg <= last_reg))
        else $error("rotation running on an empty ring or past its last step");

    // An enqueue into a queue with room grows it by one.
    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_ENQ) && (cnt_reg != CW'(DEPTH)))
        |=> (cnt_reg == $past(cnt_inc)))
        else $error("enqueue did not grow the queue");

    // A full report always goes with a full count.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ST_FULL)) |-> (rsp_reg.count == 5'(DEPTH)))
        else $error("full status with a count below depth");

    // A finished response is not overwritten while it waits.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !rsp_load)
        else $error("response register loaded while stalled");

endmodule

// ===== bench/shifting_queue_with_search_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_queue_with_search_test: self-checking bench for the search queue
//
// Drives enqueue, dequeue, locate and remove-at requests through the request
// channel. A shadow queue predicts every response. The response check runs
// in its own process and compares each response transfer, field by field,
// against the oldest prediction. A directed part covers the empty and full
// edges and bad positions. Random traffic then runs with and without idle
// gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module shifting_queue_with_search_test;

    import sqs_pkg::*;

    localparam int QDEPTH = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow copy of the queue contents and its fill level.
    logic signed [31:0] shadow_cells [QDEPTH];
    int unsigned shadow_fill = 0;

    // Responses predicted for accepted requests, oldest first.
    rsp_t predicted_responses [$];

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned rsp_count = 0;
    int unsigned cmd_seen [4] = '{0, 0, 0, 0};
    int unsigned status_seen [4] = '{0, 0, 0, 0};

    shifting_queue_with_search #(
        .DEPTH(QDEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    // Remove the shadow entry at a 0-based slot and close the gap.
    function automatic logic signed [31:0] take_entry(int unsigned slot);
        logic signed [31:0] taken;
        taken = shadow_cells[slot];
        for (int unsigned k = slot; k + 1 < shadow_fill; k++)
        begin
            shadow_cells[k] = shadow_cells[k + 1];
        end
        shadow_fill--;
        return taken;
    endfunction

    // Apply one command to the shadow queue and return the response it gives.
    function automatic rsp_t apply_command(req_t r);
        rsp_t o;
        o = '0;
        o.status = ST_OK;
        case (r.cmd)
            CMD_ENQ:
            begin
                if (shadow_fill >= QDEPTH)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    shadow_cells[shadow_fill] = r.value;
                    shadow_fill++;
                end
            end
            CMD_DEQ:
            begin
                if (shadow_fill == 0)
                    o.status = ST_EMPTY;
                else
                    o.data_out = take_entry(0);
            end
            CMD_LOC:
            begin
                // Only occupied entries are compared; the first match wins.
                for (int unsigned k = 0; k < shadow_fill; k++)
                begin
                    if (o.found_position == 0 && shadow_cells[k] == r.value)
                        o.found_position = 5'(k + 1);
                end
            end
            default:
            begin
                // The empty check comes before the position check.
                if (shadow_fill == 0)
                    o.status = ST_EMPTY;
                else if (r.position == 0 || r.position > shadow_fill)
                    o.status = ST_BADPOS;
                else
                    o.data_out = take_entry(r.position - 1);
            end
        endcase
        o.count = 5'(shadow_fill);
        return o;
    endfunction

    // Mostly no gap; when there is one, it is usually short and now and then long.
    function automatic int unsigned pick_gap(int unsigned pct);
        if (pct == 0 || $urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2, 3: return $urandom_range(6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t make_req(logic [1:0] cmd, logic signed [31:0] value,
                                      logic [4:0] position);
        req_t r;
        r.cmd = cmd;
        r.value = value;
        r.position = position;
        return r;
    endfunction

    // Random request. Locate usually looks for a stored value, and remove-at
    // usually names a valid position, so that both reach past the error paths.
    function automatic req_t random_request(int unsigned enq_weight);
        req_t r;
        int unsigned pick;
        r.value = random_value();
        r.position = 5'($urandom_range(31));
        if ($urandom_range(99) < enq_weight)
        begin
            r.cmd = CMD_ENQ;
        end
        else
        begin
            pick = $urandom_range(2);
            r.cmd = (pick == 0) ? CMD_DEQ : (pick == 1) ? CMD_LOC : CMD_REM;
        end
        if (r.cmd == CMD_LOC && shadow_fill != 0 && $urandom_range(3) != 0)
            r.value = shadow_cells[$urandom_range(shadow_fill - 1)];
        if (r.cmd == CMD_REM && shadow_fill != 0 && $urandom_range(4) != 0)
            r.position = 5'($urandom_range(shadow_fill, 1));
        return r;
    endfunction

    // Present one request, hold it until the transfer, then predict its response.
    task automatic send_request(input req_t item);
        rsp_t predicted;
        int unsigned gap;
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = apply_command(item);
        predicted_responses.push_back(predicted);
        cmd_seen[item.cmd]++;
        status_seen[predicted.status]++;
        gap = pick_gap(send_gap_pct);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Dequeue, remove-at and locate on an empty queue.
    task automatic test_empty_queue_errors();
        send_gap_pct = 25;
        stall_pct = 25;
        send_request(make_req(CMD_DEQ, 32'sd0, 5'd0));
        send_request(make_req(CMD_REM, 32'sd0, 5'd1));
        send_request(make_req(CMD_LOC, 32'sd0, 5'd0));
    endtask

    // Fill to the limit with extreme and duplicate values, then probe the edges.
    task automatic test_full_queue_edges();
        send_request(make_req(CMD_ENQ, 32'sh8000_0000, 5'd0));
        send_request(make_req(CMD_ENQ, 32'sh7FFF_FFFF, 5'd0));
        send_request(make_req(CMD_ENQ, 32'sh7FFF_FFFF, 5'd0));
        send_request(make_req(CMD_ENQ, -32'sd1, 5'd0));
        send_request(make_req(CMD_ENQ, 32'sd0, 5'd0));
        for (int k = 5; k < QDEPTH; k++)
        begin
            send_request(make_req(CMD_ENQ, 32'sh100 + k, 5'd0));
        end
        send_request(make_req(CMD_ENQ, 32'sd77, 5'd0));
        // The first of the duplicates is reported.
        send_request(make_req(CMD_LOC, 32'sh7FFF_FFFF, 5'd0));
        send_request(make_req(CMD_LOC, 32'sh5A5A_5A5A, 5'd0));
        send_request(make_req(CMD_REM, 32'sd0, 5'd0));
        send_request(make_req(CMD_REM, 32'sd0, 5'd31));
        send_request(make_req(CMD_REM, 32'sd0, 5'd16));
        send_request(make_req(CMD_REM, 32'sd0, 5'd2));
        send_request(make_req(CMD_DEQ, 32'sd0, 5'd0));
    endtask

    // Random traffic at full rate on both sides.
    task automatic test_back_to_back(int unsigned n);
        send_gap_pct = 0;
        stall_pct = 0;
        repeat (n) send_request(random_request(45));
    endtask

    // Random traffic with idle gaps on the sender and stalls on the receiver.
    task automatic test_random_idling(int unsigned n);
        send_gap_pct = 30;
        stall_pct = 30;
        repeat (n) send_request(random_request(45));
    endtask

    // Alternate between filling and draining so both ends are visited often.
    task automatic test_fill_and_drain(int unsigned n);
        int unsigned sent;
        int unsigned weight;
        sent = 0;
        weight = 85;
        send_gap_pct = 15;
        stall_pct = 20;
        while (sent < n)
        begin
            repeat ($urandom_range(40, 20)) send_request(random_request(weight));
            sent += 30;
            weight = (weight == 85) ? 10 : 85;
        end
    endtask

    // Random stall pattern on the response side.
    initial
    begin : rsp_stall_driver
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
            begin
                hold--;
            end
            else
            begin
                hold = pick_gap(stall_pct);
                if (hold != 0)
                begin
                    rsp_stall <= 1'b1;
                    hold--;
                end
                else
                begin
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare every response transfer with the oldest prediction.
    always @(posedge clk)
    begin : rsp_checker
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_count++;
            if (predicted_responses.size() == 0)
            begin
                $display("%0t: response with none expected: %p", $time, rsp);
                mismatch_count++;
            end
            else
            begin
                want = predicted_responses.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("data_out", want.data_out, rsp.data_out);
                check_field("found_position", 32'(want.found_position),
                            32'(rsp.found_position));
                check_field("count", 32'(want.count), 32'(rsp.count));
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue_errors();
        test_full_queue_edges();
        test_back_to_back(300);
        test_random_idling(500);
        test_fill_and_drain(450);

        req_valid <= 1'b0;
        while (predicted_responses.size() != 0)
            @(posedge clk);
        repeat (2 * QDEPTH + 4) @(posedge clk);

        $display("Covered %0d requests: %0d enqueue, %0d dequeue, %0d locate, %0d remove-at.",
                 cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
                 cmd_seen[CMD_ENQ], cmd_seen[CMD_DEQ], cmd_seen[CMD_LOC], cmd_seen[CMD_REM]);
        $display("Checked %0d responses (ok %0d, full %0d, empty %0d, bad position %0d).",
                 rsp_count, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_BADPOS]);
        if (mismatch_count == 0)
            $display("PASS shifting_queue_with_search");
        else
            $display("FAIL shifting_queue_with_search");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(5_000_000);
        $display("FAIL shifting_queue_with_search");
        $finish;
    end

endmodule
